// ===== src/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the character table for the base64 stream encoder
// no dependencies; imported by every module of the encoder
`timescale 1ns / 1ps

package b64e_pkg;

  // padding character
  localparam logic [7:0] B64E_PAD_CHAR   = 8'h3D;
  // depth of the group queue between front and back
  localparam int unsigned B64E_QUEUE_DEPTH = 2;
  localparam int unsigned B64E_QPTR_W      = $clog2(B64E_QUEUE_DEPTH);
  localparam int unsigned B64E_QCNT_W      = $clog2(B64E_QUEUE_DEPTH + 1);
  // index of the last character of a group
  localparam logic [1:0]  B64E_LAST_CHAR  = 2'd3;
  // pending byte count that completes a group
  localparam logic [1:0]  B64E_FULL_HELD  = 2'd2;

  // input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64e_in_t;

  // output transaction payload
  typedef struct packed {
    logic [7:0] code_char;
    logic       run_last;
    logic       message_end;
  } b64e_out_t;

  // one classified group handed from front to back
  typedef struct packed {
    logic [23:0] bits;    // zero-filled 24-bit group, oldest byte on top
    logic [1:0]  filled;  // number of real bytes, 1 to 3
    logic        fin;     // group closes the message
  } b64e_group_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  // 6-bit index to standard alphabet character
  function automatic logic [7:0] b64e_char(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < 6'd26) begin
      ch = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      ch = 8'h61 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      ch = 8'h30 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== src/base64_stream_encoder_unit.sv =====
// base64_stream_encoder_unit: top level of the streaming base64 encoder
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
`timescale 1ns / 1ps

// Encodes a byte stream to standard base64 (A-Z a-z 0-9 + /), one byte per input
// transaction and one character per output transaction. Bytes are taken every cycle
// while the two-entry group queue has room; each third byte, or any byte flagged
// final_byte, closes a group that yields four characters, padded with '=' when the
// final group holds one or two bytes. The character stage sends one character per
// cycle while a group is queued and out_stall does not hold its output register;
// a closed group passes through a queue slot and then the output register. run_last
// marks the fourth character of each group and message_end the fourth character of
// the final group. There are no configuration registers.
module base64_stream_encoder_unit
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  b64e_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output b64e_out_t out_data
);

  b64e_qstat_t qstat;
  b64e_group_t push_group;
  b64e_group_t head;
  logic        push;
  logic        pop;

  // byte intake and grouping
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .qstat      (qstat),
    .push       (push),
    .push_group (push_group)
  );

  // group queue
  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // character generation
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/b64e_front.sv =====
// b64e_front: accepts raw bytes, keeps up to two pending, and forms zero-filled groups
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_front
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  b64e_in_t    in_data,
  input  b64e_qstat_t qstat,
  output logic        push,
  output b64e_group_t push_group
);

  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic [1:0]  cnt;
  logic        accept;
  logic        emit;

  // queue full holds off the input side
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  // a count of three is treated as two
  assign cnt  = (held_count > B64E_FULL_HELD) ? B64E_FULL_HELD : held_count;
  assign emit = in_data.final_byte || (cnt == B64E_FULL_HELD);
  assign push = accept && emit;

  // assemble the group from pending bytes and the new byte
  always_comb begin
    push_group.fin    = in_data.final_byte;
    push_group.filled = cnt + 2'd1;
    case (cnt)
      2'd0:    push_group.bits = {in_data.data_byte, 16'h0000};
      2'd1:    push_group.bits = {held_bytes[7:0], in_data.data_byte, 8'h00};
      default: push_group.bits = {held_bytes, in_data.data_byte};
    endcase
  end

  // pending byte store
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= 16'h0000;
      held_count <= 2'd0;
    end else if (accept) begin
      if (emit) begin
        held_bytes <= 16'h0000;
        held_count <= 2'd0;
      end else begin
        held_bytes <= {held_bytes[7:0], in_data.data_byte};
        held_count <= cnt + 2'd1;
      end
    end
  end

  a_held_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("pending byte count reached three");

endmodule

// ===== src/b64e_queue.sv =====
// b64e_queue: short queue of classified groups between front and back
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_queue
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64e_group_t push_group,
  input  logic        pop,
  output b64e_group_t head,
  output b64e_qstat_t qstat
);

  b64e_group_t             slots [B64E_QUEUE_DEPTH];
  logic [B64E_QPTR_W-1:0]  wr_ptr;
  logic [B64E_QPTR_W-1:0]  rd_ptr;
  logic [B64E_QCNT_W-1:0]  count;

  assign qstat.full  = (count == B64E_QCNT_W'(B64E_QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == B64E_QPTR_W'(B64E_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == B64E_QPTR_W'(B64E_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("group queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("group queue underflow");

endmodule

// ===== src/b64e_back.sv =====
// b64e_back: turns queued groups into four characters each, one per cycle unless stalled, into an output register
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  b64e_group_t head,
  input  b64e_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output b64e_out_t   out_data
);

  logic [1:0] char_idx;
  logic [5:0] sextet;
  logic       load;
  b64e_out_t  char_next;

  // a group is queued and the output register is free or being drained this cycle
  assign load = !qstat.empty && (!out_valid || !out_stall);
  assign pop  = load && (char_idx == B64E_LAST_CHAR);

  // pick the sextet, most significant first
  always_comb begin
    case (char_idx)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
  end

  // character, padding and end flags
  always_comb begin
    char_next.code_char   = (char_idx > head.filled) ? B64E_PAD_CHAR : b64e_char(sextet);
    char_next.run_last    = (char_idx == B64E_LAST_CHAR);
    char_next.message_end = (char_idx == B64E_LAST_CHAR) && head.fin;
  end

  // character counter within the group
  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx <= 2'd0;
    end else if (load) begin
      char_idx <= char_idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= char_next;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.message_end |-> out_data.run_last)
    else $error("message end on a character that is not the last of its group");

  a_group_stays: assert property (@(posedge clk) disable iff (rst)
    char_idx != 2'd0 |-> !qstat.empty)
    else $error("group left the queue before all four characters were sent");

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for base64_stream_encoder_unit, byte stream in, characters out
// depends on b64e_pkg for the payload types; holds its own base64 predictor and alphabet
`timescale 1ns / 1ps

module testbench;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_IDLE_ITEMS = 400;
  localparam int TOTAL_ITEMS = 470;
  localparam logic [7:0] PAD_SYMBOL = "=";
  // alphabet packed with index 0 in the top byte
  localparam logic [511:0] SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  b64e_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  b64e_out_t out_data;

  // predictor state: bytes waiting for the rest of their group
  logic [15:0] held_pair = '0;
  logic [1:0]  held_cnt = '0;
  b64e_out_t   expected_chars[$];

  int  cycle_count = 0;
  int  error_count = 0;
  int  items_sent = 0;
  int  messages_sent = 0;
  int  chars_checked = 0;
  int  stall_left = 0;
  bit  src_idle = 1'b0;
  bit  sink_idle = 1'b0;

  base64_stream_encoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               expected_chars.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // update predictor with one accepted byte, queue any characters it completes
  task automatic predict_byte(input b64e_in_t item);
    logic [23:0] group;
    int          filled;
    int          idx;
    b64e_out_t   sym;
    if (held_cnt < 2'd2 && !item.final_byte) begin
      held_pair = {held_pair[7:0], item.data_byte};
      held_cnt = held_cnt + 2'd1;
    end else begin
      case (held_cnt)
        2'd0: begin
          group = {item.data_byte, 16'h0000};
          filled = 1;
        end
        2'd1: begin
          group = {held_pair[7:0], item.data_byte, 8'h00};
          filled = 2;
        end
        default: begin
          group = {held_pair, item.data_byte};
          filled = 3;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        idx = int'(group[18 - 6 * k +: 6]);
        sym.code_char = (k > filled) ? PAD_SYMBOL : SYMBOLS[8 * (63 - idx) +: 8];
        sym.run_last = (k == 3);
        sym.message_end = (k == 3) && item.final_byte;
        expected_chars.push_back(sym);
      end
      held_pair = '0;
      held_cnt = '0;
    end
  endtask

  // offer one byte, hold it until accepted
  task automatic send_byte(input logic [7:0] value, input logic fin);
    b64e_in_t item;
    item.data_byte = value;
    item.final_byte = fin;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(item);
    items_sent++;
    if (fin) messages_sent++;
  endtask

  // random message, lengths weighted toward short ones
  task automatic send_random_message();
    int len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 14);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // output checker and sink stall generator
  always @(posedge clk) begin : char_check
    b64e_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected character %h run_last %b message_end %b at cycle %0d",
                     out_data.code_char, out_data.run_last, out_data.message_end,
                     cycle_count);
          end
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_data.code_char !== want.code_char || out_data.run_last !== want.run_last ||
              out_data.message_end !== want.message_end) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch at cycle %0d: char exp %h got %h, run_last exp %b got %b, %s",
                       cycle_count, want.code_char, out_data.code_char, want.run_last,
                       out_data.run_last, $sformatf("message_end exp %b got %b",
                       want.message_end, out_data.message_end));
            end
          end
        end
      end
      // random stall bursts on the output
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // padding cases, groups closed by the final byte, alphabet extremes
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // all indices 62, then all 63, message closed on a full group
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    // one group then a two-byte tail
    for (int i = 1; i <= 5; i++) begin
      send_byte(8'(i), i == 5);
    end
  endtask

  // random messages with idle bursts on both sides
  task automatic test_random_idle();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    while (items_sent < RANDOM_IDLE_ITEMS) send_random_message();
  endtask

  // random messages at full rate
  task automatic test_random_streaming();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    while (items_sent < TOTAL_ITEMS) send_random_message();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_idle();
    test_random_streaming();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d bytes in %0d messages, %0d characters checked, %0d errors",
             items_sent, messages_sent, chars_checked, error_count);
    $display("directed padding and alphabet cases, random messages with stalls, full-rate tail");
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder_unit.sv
test/testbench.sv
